>>> hdl/spq_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted priority queue: sizes, field widths, status codes and the
// entry and command types shared by the interfaces, the cell and the top level.
// Depends on nothing.
package spq_pkg;

	localparam int CAPACITY      = 16;
	localparam int PRIO_BITS     = 16;
	localparam int PRIO_FIELD_W  = 16;
	localparam int DATA_W        = 32;
	localparam int OCC_W         = 5;
	localparam int STATUS_W      = 2;
	// Stored priority width: bits above PRIO_BITS are dropped on insert.
	localparam int PRIO_W        = (PRIO_BITS < PRIO_FIELD_W) ? PRIO_BITS : PRIO_FIELD_W;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} spq_op_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [DATA_W-1:0] data;
	} spq_entry_t;

	// Broadcast to every cell in the cycle an item is accepted.
	typedef struct packed {
		logic       ins;
		logic       del;
		spq_entry_t new_entry;
	} spq_cmd_t;

endpackage

>>> hdl/spq_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for the field widths.
interface spq_req_if import spq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [PRIO_FIELD_W-1:0]    priority_req;
	logic signed [DATA_W-1:0]   payload;

	modport source (output valid, mode, priority_req, payload, input ready);
	modport sink   (input valid, mode, priority_req, payload, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic [PRIO_FIELD_W-1:0]    out_priority;
	logic signed [DATA_W-1:0]   out_payload;
	logic [OCC_W-1:0]           occupancy;

	modport source (output valid, status, out_priority, out_payload, occupancy, input ready);
	modport sink   (input valid, status, out_priority, out_payload, occupancy, output ready);
endinterface

>>> hdl/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted queue. It compares its entry with the new priority and
// shifts toward the back on insert or toward the front on delete. Uses spq_pkg.
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  spq_cmd_t   cmd,
	input  logic       occupied,
	input  logic       left_keep,
	input  spq_entry_t left_entry,
	input  spq_entry_t right_entry,
	output logic       keep,
	output spq_entry_t entry
);

	spq_entry_t entry_q;

	// An occupied slot whose priority does not exceed the new one stays put; since
	// the row is sorted, the slots that stay form a prefix.
	assign keep  = occupied && (entry_q.prio <= cmd.new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!keep) begin
				entry_q <= left_keep ? cmd.new_entry : left_entry;
			end
		end else if (cmd.del) begin
			entry_q <= right_entry;
		end
	end

endmodule

>>> hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue: top level with the row of cells, the entry count and the
// response register. Depends on spq_pkg, spq_if and spq_cell.
//
// Usage:
//   req carries one operation per transfer: mode 0 inserts (priority_req, payload),
//   mode 1 removes the front entry. A lower priority number is served first and
//   equal priorities leave in arrival order.
//   rsp returns exactly one result per request: status (done, full or empty),
//   the removed entry on a successful delete (zero otherwise) and the occupancy
//   after the operation.
//   The result is registered at the edge that accepts the request. Throughput is
//   one request per cycle while rsp is drained; every cell compares its own
//   priority with the new one in parallel and shifts in the same cycle.
//   req.ready is high while the response register is empty or being drained, so
//   a stalled receiver holds the result and stops further requests.
//   After reset the queue is empty and no response is pending. Slot contents
//   have no reset; only slots below the entry count are ever read.
module sorted_priority_queue import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	logic [CNT_W-1:0]  count_q;
	logic              accept;
	logic              is_full;
	logic              is_empty;
	spq_cmd_t          cmd;
	logic              keep_w  [CAPACITY];
	spq_entry_t        entry_w [CAPACITY];

	logic              rsp_valid_q;
	spq_status_t       status_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic [DATA_W-1:0] out_data_q;
	logic [CNT_W-1:0]  occ_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign is_empty  = (count_q == '0);

	always_comb begin
		cmd.ins            = accept && (spq_op_t'(req.mode) == OP_INSERT) && !is_full;
		cmd.del            = accept && (spq_op_t'(req.mode) == OP_DELETE) && !is_empty;
		cmd.new_entry.prio = req.priority_req[PRIO_W-1:0];
		cmd.new_entry.data = req.payload;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic       left_keep;
		spq_entry_t left_entry;
		spq_entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_keep  = 1'b1;
			assign left_entry = cmd.new_entry;
		end else begin : g_body
			assign left_keep  = keep_w[i-1];
			assign left_entry = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = entry_w[i];
		end else begin : g_inner
			assign right_entry = entry_w[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (CNT_W'(i) < count_q),
			.left_keep   (left_keep),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.keep        (keep_w[i]),
			.entry       (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.del) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (spq_op_t'(req.mode) == OP_INSERT) begin
				status_q   <= is_full ? ST_FULL : ST_DONE;
				out_prio_q <= '0;
				out_data_q <= '0;
				occ_q      <= is_full ? count_q : count_q + 1'b1;
			end else if (is_empty) begin
				status_q   <= ST_EMPTY;
				out_prio_q <= '0;
				out_data_q <= '0;
				occ_q      <= count_q;
			end else begin
				status_q   <= ST_DONE;
				out_prio_q <= entry_w[0].prio;
				out_data_q <= entry_w[0].data;
				occ_q      <= count_q - 1'b1;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_priority = PRIO_FIELD_W'(out_prio_q);
	assign rsp.out_payload  = out_data_q;
	assign rsp.occupancy    = OCC_W'(occ_q);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (spq_op_t'(req.mode) == OP_INSERT) && is_full) |=> $stable(count_q))
		else $error("refused insert changed the entry count");

	a_rsp_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !rsp_valid_q) |=> (rsp.occupancy == OCC_W'(count_q)))
		else $error("reported occupancy differs from entry count");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.out_payload)))
		else $error("stalled result was not held");
`endif

endmodule

>>> tb/sv/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_priority_queue: directed and random insert/delete traffic,
// each response checked against a behavioral model of the sorted queue.
// Depends on spq_pkg, spq_if and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 4;
	localparam int MAX_WAIT       = 14;
	localparam int MISMATCH_SHOWN = 10;
	localparam int RANDOM_ITEMS   = 1830;
	localparam int DRAIN_LIMIT    = 2000;
	localparam int TIMEOUT_NS     = 10_000_000;

	typedef struct packed {
		spq_status_t             status;
		logic [PRIO_FIELD_W-1:0] prio;
		logic [DATA_W-1:0]       data;
		logic [OCC_W-1:0]        occ;
	} spq_result_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model of the stored entries, kept in service order.
	logic [PRIO_W-1:0] model_prio [CAPACITY];
	logic [DATA_W-1:0] model_data [CAPACITY];
	int                model_len = 0;
	spq_result_t       pending_results [$];

	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	int mismatches   = 0;
	int results_seen = 0;
	int n_insert     = 0;
	int n_delete     = 0;
	int n_full       = 0;
	int n_empty      = 0;
	int peak_len     = 0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	initial begin
		#TIMEOUT_NS;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic spq_result_t apply_op(spq_op_t op, logic [PRIO_FIELD_W-1:0] prio,
			logic [DATA_W-1:0] data);
		spq_result_t       res;
		logic [PRIO_W-1:0] kept;
		int                pos;
		kept       = prio[PRIO_W-1:0];
		res        = '0;
		res.status = ST_DONE;
		pos        = 0;
		if (op == OP_INSERT) begin
			n_insert++;
			if (model_len >= CAPACITY) begin
				res.status = ST_FULL;
				n_full++;
			end else begin
				// New entry goes behind every entry of equal or lower number.
				while (pos < model_len && model_prio[pos] <= kept)
					pos++;
				for (int i = model_len; i > pos; i--) begin
					model_prio[i] = model_prio[i-1];
					model_data[i] = model_data[i-1];
				end
				model_prio[pos] = kept;
				model_data[pos] = data;
				model_len++;
				if (model_len > peak_len)
					peak_len = model_len;
			end
		end else begin
			n_delete++;
			if (model_len == 0) begin
				res.status = ST_EMPTY;
				n_empty++;
			end else begin
				res.prio = PRIO_FIELD_W'(model_prio[0]);
				res.data = model_data[0];
				for (int i = 0; i + 1 < model_len; i++) begin
					model_prio[i] = model_prio[i+1];
					model_data[i] = model_data[i+1];
				end
				model_len--;
			end
		end
		res.occ = OCC_W'(model_len);
		return res;
	endfunction

	function automatic void note_error(string msg);
		mismatches++;
		if (mismatches <= MISMATCH_SHOWN)
			$display("%0t ns: %s", $time, msg);
	endfunction

	// Response side: random stalls, then each transfer is compared with the oldest
	// expectation.
	initial begin : rsp_checker
		int          stall;
		spq_result_t exp_res;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
			results_seen++;
			if (pending_results.size() == 0) begin
				note_error($sformatf("response with none expected: status %0d occupancy %0d",
					rsp_ch.status, rsp_ch.occupancy));
			end else begin
				exp_res = pending_results.pop_front();
				if (rsp_ch.status !== exp_res.status)
					note_error($sformatf("status: expected %0d, got %0d",
						exp_res.status, rsp_ch.status));
				if (rsp_ch.out_priority !== exp_res.prio)
					note_error($sformatf("out_priority: expected 0x%04h, got 0x%04h",
						exp_res.prio, rsp_ch.out_priority));
				if (rsp_ch.out_payload !== exp_res.data)
					note_error($sformatf("out_payload: expected 0x%08h, got 0x%08h",
						exp_res.data, rsp_ch.out_payload));
				if (rsp_ch.occupancy !== exp_res.occ)
					note_error($sformatf("occupancy: expected %0d, got %0d",
						exp_res.occ, rsp_ch.occupancy));
			end
		end
	end

	// Drives one request after a random gap and records its expected response once
	// the transfer has happened. Valid stays high for a back-to-back follower.
	task automatic send_op(spq_op_t op, logic [PRIO_FIELD_W-1:0] prio,
			logic [DATA_W-1:0] data);
		int gap;
		gap = send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= op;
		req_ch.priority_req <= prio;
		req_ch.payload      <= data;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_results.push_back(apply_op(op, prio, data));
	endtask

	task automatic wait_for_results(int limit);
		int waited;
		waited = 0;
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic test_empty_delete();
		// Request fields are nonzero to show they are ignored on a delete.
		send_op(OP_DELETE, '1, 32'h7FFF_FFFF);
	endtask

	task automatic test_fill_to_capacity();
		logic [PRIO_FIELD_W-1:0] prio;
		logic [DATA_W-1:0]       data;
		for (int i = 0; i < CAPACITY; i++) begin
			case (i)
				0: begin
					prio = '1;
					data = 32'h7FFF_FFFF;
				end
				1: begin
					prio = '0;
					data = 32'h8000_0000;
				end
				2: begin
					prio = 16'h8000;
					data = '1;
				end
				3: begin
					prio = 16'h8000;
					data = '0;
				end
				default: begin
					// Every third entry shares a priority to exercise arrival order.
					prio = (i % 3 == 0) ? 16'h8000 : PRIO_FIELD_W'($urandom);
					data = $urandom;
				end
			endcase
			send_op(OP_INSERT, prio, data);
		end
	endtask

	task automatic test_insert_when_full();
		send_op(OP_INSERT, '0, 32'h1234_5678);
		send_op(OP_INSERT, '1, '1);
	endtask

	task automatic test_partial_drain();
		for (int i = 0; i < 4; i++)
			send_op(OP_DELETE, PRIO_FIELD_W'($urandom), $urandom);
	endtask

	// Blocks of traffic lean toward filling or draining so the queue swings between
	// full and empty; priorities are often drawn from a narrow band to force ties.
	task automatic test_random_traffic(int count);
		int                      sent;
		int                      block;
		int                      fill_pct;
		bit                      paused;
		spq_op_t                 op;
		logic [PRIO_FIELD_W-1:0] prio;
		logic [DATA_W-1:0]       data;
		sent   = 0;
		paused = 1'b0;
		while (sent < count) begin
			block = $urandom_range(8, 48);
			case ($urandom_range(0, 2))
				0:       fill_pct = 80;
				1:       fill_pct = 20;
				default: fill_pct = 50;
			endcase
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_idle_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < block && sent < count; i++) begin
				op = ($urandom_range(0, 99) < fill_pct) ? OP_INSERT : OP_DELETE;
				case ($urandom_range(0, 3))
					0:       prio = PRIO_FIELD_W'($urandom_range(0, 3));
					1:       prio = $urandom_range(0, 1) ? '1 : '0;
					2:       prio = PRIO_FIELD_W'($urandom_range(16'h7FFC, 16'h8003));
					default: prio = PRIO_FIELD_W'($urandom);
				endcase
				case ($urandom_range(0, 7))
					0:       data = 32'h8000_0000;
					1:       data = 32'h7FFF_FFFF;
					default: data = $urandom;
				endcase
				send_op(op, prio, data);
				sent++;
			end
			if (!paused && sent >= count / 2) begin
				wait_for_results(DRAIN_LIMIT);
				paused = 1'b1;
			end
		end
	endtask

	initial begin : run
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.mode         <= OP_INSERT;
		req_ch.priority_req <= '0;
		req_ch.payload      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_delete();
		test_fill_to_capacity();
		test_insert_when_full();
		test_partial_drain();
		wait_for_results(DRAIN_LIMIT);
		test_random_traffic(RANDOM_ITEMS);

		wait_for_results(DRAIN_LIMIT);
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			note_error($sformatf("%0d expected responses never arrived",
				pending_results.size()));

		$display("Ran %0d inserts (%0d refused on a full queue) and %0d deletes (%0d on an empty queue).",
			n_insert, n_full, n_delete, n_empty);
		$display("Checked %0d responses, peak occupancy %0d of %0d, %0d mismatches.",
			results_seen, peak_len, CAPACITY, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
